// ----- hw/rtl/int_to_decimal_ascii_top_defines.svh -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top_defines.svh
// Assertion macros used by the checker file of the decimal text block.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst is high.
`define ITDA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst is high.
`define ITDA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg
// Widths, types, character codes and helpers of the decimal text block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

  localparam int VALUE_BITS = 32;

  // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
  function automatic int digits_for(input int bits);
    logic [63:0] m;
    int          n;
    m = 64'd1 << (bits - 1);
    n = 0;
    while (m != 64'd0) begin
      m = m / 64'd10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int DIGITS      = digits_for(VALUE_BITS);
  localparam int IDX_W       = $clog2(DIGITS);
  localparam int BCD_W       = DIGITS * 4;
  // Double-dabble shifts per pipeline stage.
  localparam int STEP        = 4;
  localparam int CONV_STAGES = (VALUE_BITS + STEP - 1) / STEP;
  localparam int PAD_W       = CONV_STAGES * STEP;
  localparam int CHAR_W      = 6;

  typedef logic [3:0]                digit_t;
  typedef digit_t [DIGITS-1:0]       bcd_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [PAD_W-1:0]          pad_t;
  typedef logic [VALUE_BITS-1:0]     mag_t;
  typedef logic [CHAR_W-1:0]         char_t;

  localparam char_t CHAR_MINUS = char_t'(45);
  localparam char_t CHAR_ZERO  = char_t'(48);

  // Add-3 correction of every BCD digit of five or more.
  function automatic bcd_t add3(input bcd_t b);
    bcd_t r;
    r = b;
    for (int i = 0; i < DIGITS; i++) begin
      if (b[i] >= 4'd5) begin
        r[i] = b[i] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/int_to_decimal_ascii_top.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Signed integer to decimal ASCII text, one character per output word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : in_valid / in_stall, payload value (signed, VALUE_BITS).
//   Output channel : out_valid / out_stall, payload character (6-bit ASCII)
//                    and last, high on the final character of a number.
//   A negative number starts with '-', then the digits, most significant
//   first, no leading zeros; zero gives a single '0'.
//   Path: the first character of a number passes the input register, 8
//   double-dabble stages, the leading-digit stage, the serialiser and the
//   output register.
//   Throughput: while out_stall is low the serialiser sends one character
//   per cycle, a sign plus up to ten digits per number; a new number can
//   enter the pipeline in every cycle while room remains.
//   Stall: out_stall freezes the output register; the stall ripples back
//   through the pipeline and in_stall rises once every stage is full.
//   Nothing is lost or repeated.
//   Reset (rst, synchronous) empties every stage; no state carries over
//   from one number to the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_ascii_top
  import itda_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic        [CHAR_W-1:0]     character,
  output      logic                         last
);

  // --------------------------------------------------------------------------
  // Conversion pipeline: stage 0 holds sign and magnitude, stages 1..N each
  // run STEP double-dabble shifts. A stage moves when it is empty or the
  // stage after it moves.
  // --------------------------------------------------------------------------
  logic st_valid [0:CONV_STAGES];
  logic st_neg   [0:CONV_STAGES];
  bcd_t st_bcd   [0:CONV_STAGES];
  pad_t st_bin   [0:CONV_STAGES];
  logic st_adv   [0:CONV_STAGES];

  // Leading-digit stage
  logic ld_valid;
  logic ld_neg;
  bcd_t ld_bcd;
  idx_t ld_top;
  idx_t ld_top_next;
  logic ld_adv;

  // Serialiser
  logic ser_busy;
  logic ser_sign;
  bcd_t ser_bcd;
  idx_t ser_idx;
  logic ser_emit;
  logic ser_done;
  logic ser_load;
  logic out_adv;
  char_t char_next;
  logic  last_next;

  logic in_neg;
  mag_t in_mag;

  assign in_stall = !st_adv[0];

  // Magnitude as unsigned, so the most negative value converts correctly.
  assign in_neg = value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~mag_t'(value) + mag_t'(1)) : mag_t'(value);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (st_adv[0]) begin
      st_valid[0] <= in_valid;
    end
    if (st_adv[0]) begin
      st_neg[0] <= in_neg;
      st_bcd[0] <= '0;
      st_bin[0] <= pad_t'(in_mag);
    end
  end

  generate
    for (genvar k = 0; k < CONV_STAGES; k++) begin : g_conv
      bcd_t bcd_next;
      pad_t bin_next;

      always_comb begin
        logic [BCD_W:0] wide;
        bcd_next = st_bcd[k];
        bin_next = st_bin[k];
        for (int j = 0; j < STEP; j++) begin
          bcd_next = add3(bcd_next);
          wide     = {bcd_next, bin_next[PAD_W-1]};
          bcd_next = wide[BCD_W-1:0];
          bin_next = {bin_next[PAD_W-2:0], 1'b0};
        end
      end

      assign st_adv[k] = !st_valid[k] || st_adv[k+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          st_valid[k+1] <= 1'b0;
        end else if (st_adv[k+1]) begin
          st_valid[k+1] <= st_valid[k];
        end
        if (st_adv[k+1]) begin
          st_neg[k+1] <= st_neg[k];
          st_bcd[k+1] <= bcd_next;
          st_bin[k+1] <= bin_next;
        end
      end
    end
  endgenerate

  assign st_adv[CONV_STAGES] = !st_valid[CONV_STAGES] || ld_adv;

  // --------------------------------------------------------------------------
  // Leading-digit search: highest non-zero digit, zero gives digit 0.
  // --------------------------------------------------------------------------
  always_comb begin
    ld_top_next = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (st_bcd[CONV_STAGES][i] != 4'd0) begin
        ld_top_next = idx_t'(i);
      end
    end
  end

  assign ld_adv = !ld_valid || ser_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_valid <= 1'b0;
    end else if (ld_adv) begin
      ld_valid <= st_valid[CONV_STAGES];
    end
    if (ld_adv) begin
      ld_neg <= st_neg[CONV_STAGES];
      ld_bcd <= st_bcd[CONV_STAGES];
      ld_top <= ld_top_next;
    end
  end

  // --------------------------------------------------------------------------
  // Serialiser: sign first if pending, then digits from ld_top down to 0.
  // Takes the next number in the cycle its final character goes out.
  // --------------------------------------------------------------------------
  assign out_adv  = !out_valid || !out_stall;
  assign ser_emit = ser_busy && out_adv;
  assign ser_done = ser_emit && !ser_sign && (ser_idx == '0);
  assign ser_load = ld_valid && (!ser_busy || ser_done);

  always_comb begin
    if (ser_sign) begin
      char_next = CHAR_MINUS;
      last_next = 1'b0;
    end else begin
      char_next = CHAR_ZERO + char_t'(ser_bcd[ser_idx]);
      last_next = (ser_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_busy <= 1'b0;
    end else if (ser_load) begin
      ser_busy <= 1'b1;
    end else if (ser_done) begin
      ser_busy <= 1'b0;
    end
    if (ser_load) begin
      ser_sign <= ld_neg;
      ser_bcd  <= ld_bcd;
      ser_idx  <= ld_top;
    end else if (ser_emit) begin
      if (ser_sign) begin
        ser_sign <= 1'b0;
      end else if (ser_idx != '0) begin
        ser_idx <= ser_idx - idx_t'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= ser_emit;
    end
    if (ser_emit) begin
      character <= char_next;
      last      <= last_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/itda_checker.sv -----
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks on the decimal text block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "int_to_decimal_ascii_top_defines.svh"

module itda_checker
  import itda_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [CHAR_W-1:0] character,
  input wire logic              last
);

  // Held word keeps its contents.
  `ITDA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(character) && $stable(last), "output word changed under stall")

  // Only '-' or a decimal digit ever leaves.
  `ITDA_ASSERT_IMP(a_char_code, out_valid, (character == CHAR_MINUS) || ((character >= CHAR_ZERO) && (character <= CHAR_ZERO + char_t'(9))), "character outside '-' and '0'..'9'")

  // A minus sign is never the end of a number.
  `ITDA_ASSERT_IMP(a_minus_not_last, out_valid && (character == CHAR_MINUS), !last, "minus sign flagged last")

  // Output is empty in the cycle after reset.
  `ITDA_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid, "output valid straight after reset")

endmodule

bind int_to_decimal_ascii_top itda_checker u_itda_checker (.*);

`default_nettype wire
